/* design/rse_pkg.sv */
// rse_pkg: shared types, constants and helpers for the rpn stack evaluator
// no dependencies
package rse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int WORD_BITS   = 32;
  localparam int CMDQ_DEPTH  = 4;

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  typedef logic [WORD_BITS-1:0] word_t;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_MUL   = 8'd42;
  localparam logic [7:0] CH_ADD   = 8'd43;
  localparam logic [7:0] CH_SUB   = 8'd45;
  localparam logic [7:0] CH_DIV   = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DIV
  } op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_UNDER,
    ST_OVER,
    ST_DIVZERO
  } status_e;

  typedef struct packed {
    logic  push;
    logic  show;
    logic  last;
    op_e   op;
    word_t val;
  } cmd_t;

  function automatic logic [31:0] to_out32(word_t w);
    return 32'(w);
  endfunction

endpackage

/* design/rse_ram.sv */
// rse_ram: generic single write port ram with registered read
// no dependencies
module rse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/rse_front.sv */
// rse_front: accepts characters, builds pending numbers, queues commands
// depends on rse_pkg
module rse_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    ch_i,
  input  logic          last_i,
  output logic          cmd_valid_o,
  output rse_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import rse_pkg::*;

  localparam int QP_W = $clog2(CMDQ_DEPTH);
  localparam int QC_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t            q_mem_q [CMDQ_DEPTH];
  logic [QP_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0] q_cnt_q;

  word_t accum_q, accum_d;
  logic  pend_q, pend_d;

  logic  accept, enq, is_digit;
  cmd_t  cmd_new;
  word_t accum_next;

  assign full     = (q_cnt_q == QC_W'(CMDQ_DEPTH));
  assign accept   = push && !full;
  assign is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign accum_next = (accum_q << 3) + (accum_q << 1) + word_t'(ch_i - CH_ZERO);

  always_comb begin
    cmd_new      = '0;
    cmd_new.last = last_i;
    cmd_new.op   = OP_NONE;
    cmd_new.val  = accum_q;
    accum_d      = accum_q;
    pend_d       = pend_q;
    enq          = 1'b0;
    priority if (is_digit) begin
      accum_d      = accum_next;
      pend_d       = 1'b1;
      cmd_new.show = 1'b1;
      cmd_new.val  = accum_next;
      enq          = last_i;
    end else if (ch_i == CH_SPACE) begin
      cmd_new.push = pend_q;
      accum_d      = '0;
      pend_d       = 1'b0;
      enq          = pend_q || last_i;
    end else if (ch_i == CH_MUL || ch_i == CH_ADD || ch_i == CH_SUB || ch_i == CH_DIV) begin
      cmd_new.push = pend_q;
      accum_d      = '0;
      pend_d       = 1'b0;
      enq          = 1'b1;
      unique case (ch_i)
        CH_MUL:  cmd_new.op = OP_MUL;
        CH_ADD:  cmd_new.op = OP_ADD;
        CH_SUB:  cmd_new.op = OP_SUB;
        default: cmd_new.op = OP_DIV;
      endcase
    end else begin
      cmd_new.show = pend_q;
      enq          = last_i;
    end
    if (last_i) begin
      accum_d = '0;
      pend_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q  <= '0;
      pend_q   <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      if (accept) begin
        accum_q <= accum_d;
        pend_q  <= pend_d;
      end
      if (accept && enq) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (cmd_pop_i && cmd_valid_o) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      q_cnt_q <= q_cnt_q + QC_W'(accept && enq) - QC_W'(cmd_pop_i && cmd_valid_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && enq) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign cmd_valid_o = (q_cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

endmodule

/* design/rse_div.sv */
// rse_div: iterative unsigned restoring divider, one quotient bit per cycle
// depends on rse_pkg
module rse_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  rse_pkg::word_t dividend_i,
  input  rse_pkg::word_t divisor_i,
  output logic           done_o,
  output rse_pkg::word_t quotient_o
);
  import rse_pkg::*;

  localparam int SC_W = $clog2(WORD_BITS + 1);

  word_t           rem_q, quo_q, dvs_q;
  logic [SC_W-1:0] step_q;
  logic            busy_q, done_q;

  logic [WORD_BITS:0] shifted, diff;
  logic               ge;

  assign shifted = {rem_q, quo_q[WORD_BITS-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = (shifted >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= SC_W'(WORD_BITS);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == SC_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
      quo_q <= {quo_q[WORD_BITS-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* design/rse_back.sv */
// rse_back: executes queued commands on the operand stack, holds the result item
// depends on rse_pkg, rse_ram, rse_div
module rse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  rse_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty,
  input  logic          pop,
  output logic [31:0]   value_o,
  output logic [1:0]    status_o
);
  import rse_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PUSH = 4'd1;
  localparam logic [3:0] S_OP   = 4'd2;
  localparam logic [3:0] S_RDB  = 4'd3;
  localparam logic [3:0] S_EXEC = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_WB   = 4'd6;
  localparam logic [3:0] S_END  = 4'd7;
  localparam logic [3:0] S_RES  = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  status_e          err_q, err_d;
  cmd_t             cmd_q, cmd_d;
  word_t            b_q, b_d, res_q, res_d;
  logic             neg_q, neg_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_value_q, out_value_d;
  status_e     out_status_q, out_status_d;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr, top_idx, nos_idx;
  word_t             wdata, rdata;
  logic              div_start, div_done;
  word_t             div_a, div_b, div_q;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;

  assign cnt_m1  = cnt_q - 1'b1;
  assign cnt_m2  = cnt_q - 2'd2;
  assign top_idx = cnt_m1[ADDR_W-1:0];
  assign nos_idx = cnt_m2[ADDR_W-1:0];

  rse_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign div_a = rdata[WORD_BITS-1] ? (~rdata + 1'b1) : rdata;
  assign div_b = b_q[WORD_BITS-1] ? (~b_q + 1'b1) : b_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    err_d        = err_q;
    cmd_d        = cmd_q;
    b_d          = b_q;
    res_d        = res_q;
    neg_d        = neg_q;
    out_valid_d  = out_valid_q && !pop;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    cmd_pop_o    = 1'b0;
    we           = 1'b0;
    waddr        = cnt_q[ADDR_W-1:0];
    wdata        = cmd_q.val;
    raddr        = top_idx;
    div_start    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = S_PUSH;
        end
      end
      S_PUSH: begin
        if (cmd_q.push && err_q == ST_OK) begin
          if (cnt_q == CNT_W'(STACK_DEPTH)) begin
            err_d = ST_OVER;
          end else begin
            we    = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
        state_d = S_OP;
      end
      S_OP: begin
        if (cmd_q.op == OP_NONE || err_q != ST_OK) begin
          state_d = S_END;
        end else if (cnt_q < CNT_W'(2)) begin
          err_d   = ST_UNDER;
          state_d = S_END;
        end else begin
          state_d = S_RDB;
        end
      end
      S_RDB: begin
        b_d     = rdata;
        raddr   = nos_idx;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (cmd_q.op)
          OP_MUL: begin
            res_d   = rdata * b_q;
            state_d = S_WB;
          end
          OP_ADD: begin
            res_d   = rdata + b_q;
            state_d = S_WB;
          end
          OP_SUB: begin
            res_d   = rdata - b_q;
            state_d = S_WB;
          end
          default: begin
            if (b_q == '0) begin
              err_d   = ST_DIVZERO;
              state_d = S_END;
            end else begin
              neg_d     = rdata[WORD_BITS-1] ^ b_q[WORD_BITS-1];
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = neg_q ? (~div_q + 1'b1) : div_q;
          state_d = S_WB;
        end
      end
      S_WB: begin
        we      = 1'b1;
        waddr   = nos_idx;
        wdata   = res_q;
        cnt_d   = cnt_m1;
        state_d = S_END;
      end
      S_END: begin
        state_d = cmd_q.last ? S_RES : S_IDLE;
      end
      S_RES: begin
        if (!out_valid_q || pop) begin
          out_valid_d  = 1'b1;
          out_status_d = err_q;
          out_value_d  = '0;
          if (err_q == ST_OK) begin
            priority if (cmd_q.show) begin
              out_value_d = to_out32(cmd_q.val);
            end else if (cnt_q != '0) begin
              out_value_d = to_out32(rdata);
            end else begin
              out_status_d = ST_UNDER;
            end
          end
          cnt_d   = '0;
          err_d   = ST_OK;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    b_q          <= b_d;
    res_q        <= res_d;
    neg_q        <= neg_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign empty    = !out_valid_q;
  assign value_o  = out_value_q;
  assign status_o = out_status_q;

endmodule

/* design/rpn_stack_evaluator.sv */
// rpn_stack_evaluator: characters taken one per cycle unless 4-entry command queue is full
// queued commands step through S_IDLE, S_PUSH, S_OP and S_END; + - * add S_RDB, S_EXEC, S_WB
// and / adds S_DIV (32-step iterative divider); S_RES registers the last command's result item
// the stack memory is bounded by its count and needs no clearing pass
// rst_ni clears the front accumulator, queue pointers, stack count, error and output valid
// depends on rse_pkg, rse_front, rse_back
module rpn_stack_evaluator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] value_o,
  output logic [1:0]  status_o
);
  import rse_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  rse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_OK) |-> (value_o == '0))
    else $error("result carries nonzero value with error status");

  a_cmd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && !cmd_pop) |=> cmd_valid)
    else $error("queued command lost without being taken");

  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("back end took a command from an empty queue");

endmodule

/* sim/rse_checker.sv */
`timescale 1ns / 1ps
// rse_checker: watches both queue sides of the rpn stack evaluator and predicts each result
// compares value and status against the oldest prediction and counts mismatches
// depends on rse_pkg
module rse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] value_o,
  input  logic [1:0]  status_o,
  output int          fail_cnt,
  output int          outstanding
);
  import rse_pkg::*;

  word_t       operands [STACK_DEPTH];
  int unsigned depth_cnt;
  word_t       num_acc;
  bit          num_pend;
  status_e     sticky_err;

  logic [31:0] exp_value_q [$];
  status_e     exp_status_q [$];
  logic [31:0] want_value;
  status_e     want_status;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
    fail_cnt++;
  endtask

  task automatic clear_state();
    depth_cnt  = 0;
    num_acc    = '0;
    num_pend   = 1'b0;
    sticky_err = ST_OK;
  endtask

  task automatic raise_err(status_e code);
    if (sticky_err == ST_OK) sticky_err = code;
  endtask

  task automatic push_operand(word_t w);
    if (depth_cnt >= STACK_DEPTH) begin
      raise_err(ST_OVER);
    end else begin
      operands[depth_cnt] = w;
      depth_cnt++;
    end
  endtask

  task automatic flush_number();
    if (num_pend) begin
      push_operand(num_acc);
      num_acc  = '0;
      num_pend = 1'b0;
    end
  endtask

  function automatic word_t trunc_div(word_t a, word_t b);
    word_t ma;
    word_t mb;
    word_t q;
    ma = a[WORD_BITS-1] ? -a : a;
    mb = b[WORD_BITS-1] ? -b : b;
    q  = ma / mb;
    if (a[WORD_BITS-1] != b[WORD_BITS-1]) q = -q;
    return q;
  endfunction

  task automatic apply_op(logic [7:0] c);
    word_t a;
    word_t b;
    word_t r;
    flush_number();
    if (sticky_err != ST_OK) return;
    if (depth_cnt < 2) begin
      raise_err(ST_UNDER);
      return;
    end
    b = operands[depth_cnt-1];
    a = operands[depth_cnt-2];
    if (c == CH_DIV && b == '0) begin
      raise_err(ST_DIVZERO);
      return;
    end
    depth_cnt -= 2;
    case (c)
      CH_MUL: r = a * b;
      CH_ADD: r = a + b;
      CH_SUB: r = a - b;
      default: r = trunc_div(a, b);
    endcase
    push_operand(r);
  endtask

  task automatic eval_char(logic [7:0] c, logic is_last);
    word_t res;
    res = '0;
    if (sticky_err == ST_OK) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        num_acc  = num_acc * 10 + word_t'(c - CH_ZERO);
        num_pend = 1'b1;
      end else if (c == CH_SPACE) begin
        flush_number();
      end else if (c == CH_MUL || c == CH_ADD || c == CH_SUB || c == CH_DIV) begin
        apply_op(c);
      end
    end
    if (!is_last) return;
    if (sticky_err == ST_OK) begin
      if (num_pend) res = num_acc;
      else if (depth_cnt > 0) res = operands[depth_cnt-1];
      else raise_err(ST_UNDER);
    end
    if (sticky_err != ST_OK) res = '0;
    exp_value_q.push_back(res[31:0]);
    exp_status_q.push_back(sticky_err);
    clear_state();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      exp_value_q.delete();
      exp_status_q.delete();
      fail_cnt = 0;
    end else begin
      if (push && !full) eval_char(ch_i, last_i);
      if (pop && !empty) begin
        if (exp_value_q.size() == 0) begin
          report("unexpected result", value_o, '0);
        end else begin
          want_value  = exp_value_q.pop_front();
          want_status = exp_status_q.pop_front();
          if (value_o !== want_value) report("value", value_o, want_value);
          if (status_o !== want_status) report("status", 32'(status_o), 32'(want_status));
        end
      end
    end
    outstanding = exp_value_q.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: drives expressions into the rpn stack evaluator and pops its results
// directed cases, then random expressions under three idling mixes and a long output stall
// depends on rse_pkg, rpn_stack_evaluator and rse_checker
module tb_top;
  import rse_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        push   = 1'b0;
  logic        full;
  logic [7:0]  ch_i   = '0;
  logic        last_i = 1'b0;
  logic        empty;
  logic        pop    = 1'b0;
  logic [31:0] value_o;
  logic [1:0]  status_o;

  int          fail_cnt;
  int          outstanding;
  int          item_cnt = 0;
  int          idle_cycles = 0;
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 75;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  logic [7:0] expr_q [$];
  logic [7:0] sym_set [5] = '{CH_SPACE, CH_MUL, CH_ADD, CH_SUB, CH_DIV};

  rpn_stack_evaluator uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .ch_i     (ch_i),
    .last_i   (last_i),
    .empty    (empty),
    .pop      (pop),
    .value_o  (value_o),
    .status_o (status_o)
  );

  rse_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .empty       (empty),
    .pop         (pop),
    .value_o     (value_o),
    .status_o    (status_o),
    .fail_cnt    (fail_cnt),
    .outstanding (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    ch_i   <= c;
    last_i <= is_last;
    do @(posedge clk_i); while (full);
    if (is_last || (c >= CH_ZERO && c <= CH_NINE) || c inside {sym_set}) item_cnt++;
  endtask

  task automatic send_expr();
    foreach (expr_q[i]) send_char(expr_q[i], i == expr_q.size() - 1);
    expr_q.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
    send_expr();
  endtask

  function automatic logic [7:0] pick_op();
    return sym_set[$urandom_range(1, 4)];
  endfunction

  task automatic add_number();
    int kind;
    int len;
    kind = $urandom_range(99);
    if (kind < 15) begin
      expr_q.push_back(CH_ZERO);
    end else begin
      if (kind < 60) len = $urandom_range(1, 2);
      else if (kind < 90) len = $urandom_range(3, 10);
      else len = $urandom_range(11, 14);
      repeat (len) expr_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    end
  endtask

  task automatic gen_expr();
    int kind;
    int n_num;
    int n_op;
    int depth;
    bit sep;
    string txt;
    kind = $urandom_range(99);
    if (kind < 80) begin
      // well-formed, operators only when two operands are on the stack
      n_num = $urandom_range(1, 8);
      n_op  = n_num - 1;
      depth = 0;
      sep   = 1'b0;
      while (n_num > 0 || n_op > 0) begin
        if (depth >= 2 && n_op > 0 && (n_num == 0 || $urandom_range(1))) begin
          if ($urandom_range(1)) expr_q.push_back(CH_SPACE);
          expr_q.push_back(pick_op());
          depth--;
          n_op--;
          sep = 1'b0;
        end else begin
          if (sep) expr_q.push_back(CH_SPACE);
          add_number();
          depth++;
          n_num--;
          sep = 1'b1;
        end
      end
      if ($urandom_range(3) == 0) expr_q.push_back(CH_SPACE);
    end else if (kind < 86) begin
      // 15 to 19 numbers, which overflows the 16-entry stack from 17 on
      repeat ($urandom_range(15, 19)) begin
        add_number();
        expr_q.push_back(CH_SPACE);
      end
      repeat ($urandom_range(0, 2)) expr_q.push_back(pick_op());
    end else if (kind < 89) begin
      // most negative value divided by minus one
      txt = "2147483648 0 1-/";
      foreach (txt[i]) expr_q.push_back(txt[i]);
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(1)) begin
          expr_q.push_back(8'($urandom_range(255)));
        end else if ($urandom_range(1)) begin
          expr_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        end else begin
          expr_q.push_back(sym_set[$urandom_range(4)]);
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_text("3 4*1+");
    send_text("9 0/");
    send_text("5-");
    send_text(" ");
    send_text("0 7-2/");
    send_text("6 2-1");

    while (item_cnt < 650) begin
      gen_expr();
      send_expr();
    end
    send_idle_pct = 75;
    recv_idle_pct = 8;
    while (item_cnt < 1250) begin
      gen_expr();
      send_expr();
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    while (item_cnt < 1850) begin
      gen_expr();
      send_expr();
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
